// File: src/nbji_pkg.sv
// ----------------------------------------------------------------------------
// nbji_pkg
// shared constants, cofactor index tables and sideband types of the node
// block jacobi inverse
// ----------------------------------------------------------------------------
package nbji_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int N_ENT     = 9;
  localparam int VEL_DIM   = 3;
  localparam int LANES     = 10;
  localparam int PRES_LANE = 9;
  localparam int N_ROWS    = 4;
  localparam int MASK_W    = 4;
  localparam int ROW_W     = 2;

  localparam logic [ROW_W-1:0] FIRST_ROW = 2'd0;
  localparam logic [ROW_W-1:0] LAST_ROW  = 2'd3;

  // cofactor j = e[P]*e[Q] - e[S]*e[T]
  localparam logic [3:0] ADJ_P [N_ENT] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam logic [3:0] ADJ_Q [N_ENT] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam logic [3:0] ADJ_S [N_ENT] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam logic [3:0] ADJ_T [N_ENT] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  typedef struct packed {
    logic              vsing;
    logic              psing;
    logic [MASK_W-1:0] mask;
  } side_t;

  typedef struct packed {
    logic             sat;
    logic             psing;
    logic             vsing;
    logic [ROW_W-1:0] row;
  } rflag_t;

endpackage

// File: src/nbji_det.sv
// ----------------------------------------------------------------------------
// nbji_det
// cofactor and determinant pipeline, forms the dividend and divisor
// magnitudes for every inverse entry and the pressure reciprocal
// ----------------------------------------------------------------------------
module nbji_det #(
  parameter int DATA_WIDTH = nbji_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = nbji_pkg::FRAC_BITS_DEF,
  parameter int EXT_WIDTH  = 4 * nbji_pkg::DATA_WIDTH_DEF + 1
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             en_i,
  input  logic                                             valid_i,
  input  logic [nbji_pkg::LANES-1:0][DATA_WIDTH-1:0]       ent_i,
  input  logic [nbji_pkg::MASK_W-1:0]                      mask_i,
  output logic                                             valid_o,
  output nbji_pkg::side_t                                  side_o,
  output logic [nbji_pkg::LANES-1:0][EXT_WIDTH-1:0]        num_o,
  output logic [nbji_pkg::LANES-1:0][EXT_WIDTH-1:0]        den_o,
  output logic [nbji_pkg::LANES-1:0]                       neg_o
);

  localparam int W  = DATA_WIDTH;
  localparam int AW = 2 * W + 1;
  localparam int DW = 3 * W + 3;
  localparam int NE = nbji_pkg::N_ENT;
  localparam int VD = nbji_pkg::VEL_DIM;

  logic [6:0] vld_q;

  logic signed [W-1:0]    e0_q [NE];
  logic signed [W-1:0]    pres0_q, pres1_q, pres2_q, pres3_q, pres4_q, pres5_q;
  logic [nbji_pkg::MASK_W-1:0] mask0_q, mask1_q, mask2_q, mask3_q, mask4_q, mask5_q;
  logic signed [2*W-1:0]  pa1_q [NE];
  logic signed [2*W-1:0]  pb1_q [NE];
  logic signed [W-1:0]    ed1_q [VD];
  logic signed [W-1:0]    ed2_q [VD];
  logic signed [AW-1:0]   adj2_q [NE];
  logic signed [AW-1:0]   adj3_q [NE];
  logic signed [AW-1:0]   adj4_q [NE];
  logic signed [AW-1:0]   adj5_q [NE];
  logic signed [AW-1:0]   ml3_q [VD];
  logic signed [AW-1:0]   mh3_q [VD];
  logic signed [DW-1:0]   term4_q [VD];
  logic signed [DW-1:0]   det5_q;

  logic [DW-1:0]          dmag;
  logic [AW-1:0]          amag [NE];
  logic [W:0]             pmag;
  nbji_pkg::side_t                                  side_d, side_q;
  logic [nbji_pkg::LANES-1:0][EXT_WIDTH-1:0]        num_d, num_q;
  logic [nbji_pkg::LANES-1:0][EXT_WIDTH-1:0]        den_d, den_q;
  logic [nbji_pkg::LANES-1:0]                       neg_d, neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NE; i++) begin
        e0_q[i] <= ent_i[i];
      end
      pres0_q <= ent_i[nbji_pkg::PRES_LANE];
      mask0_q <= mask_i;

      for (int j = 0; j < NE; j++) begin
        pa1_q[j] <= e0_q[nbji_pkg::ADJ_P[j]] * e0_q[nbji_pkg::ADJ_Q[j]];
        pb1_q[j] <= e0_q[nbji_pkg::ADJ_S[j]] * e0_q[nbji_pkg::ADJ_T[j]];
      end
      for (int k = 0; k < VD; k++) begin
        ed1_q[k] <= e0_q[VD*k];
      end
      pres1_q <= pres0_q;
      mask1_q <= mask0_q;

      for (int j = 0; j < NE; j++) begin
        adj2_q[j] <= pa1_q[j] - pb1_q[j];
      end
      ed2_q   <= ed1_q;
      pres2_q <= pres1_q;
      mask2_q <= mask1_q;

      // split each of the first three cofactors into a low unsigned and a high signed half
      for (int k = 0; k < VD; k++) begin
        ml3_q[k] <= ed2_q[k] * $signed({1'b0, adj2_q[k][W-1:0]});
        mh3_q[k] <= ed2_q[k] * $signed(adj2_q[k][AW-1:W]);
      end
      adj3_q  <= adj2_q;
      pres3_q <= pres2_q;
      mask3_q <= mask2_q;

      for (int k = 0; k < VD; k++) begin
        term4_q[k] <= (DW'(mh3_q[k]) <<< W) + DW'(ml3_q[k]);
      end
      adj4_q  <= adj3_q;
      pres4_q <= pres3_q;
      mask4_q <= mask3_q;

      det5_q  <= term4_q[0] + term4_q[1] + term4_q[2];
      adj5_q  <= adj4_q;
      pres5_q <= pres4_q;
      mask5_q <= mask4_q;

      side_q <= side_d;
      num_q  <= num_d;
      den_q  <= den_d;
      neg_q  <= neg_d;
    end
  end

  always_comb begin
    dmag = det5_q[DW-1] ? DW'(-det5_q) : DW'(det5_q);
    pmag = pres5_q[W-1] ? -((W+1)'(pres5_q)) : (W+1)'(pres5_q);
    for (int j = 0; j < NE; j++) begin
      amag[j]  = adj5_q[j][AW-1] ? AW'(-adj5_q[j]) : AW'(adj5_q[j]);
      num_d[j] = EXT_WIDTH'(amag[j]) << (2 * FRAC_BITS);
      den_d[j] = EXT_WIDTH'(dmag);
      neg_d[j] = adj5_q[j][AW-1] ^ det5_q[DW-1];
    end
    num_d[nbji_pkg::PRES_LANE] = EXT_WIDTH'(1) << (2 * FRAC_BITS);
    den_d[nbji_pkg::PRES_LANE] = EXT_WIDTH'(pmag);
    neg_d[nbji_pkg::PRES_LANE] = pres5_q[W-1];
    side_d.vsing = (det5_q == '0);
    side_d.psing = (pres5_q == '0);
    side_d.mask  = mask5_q;
  end

  assign valid_o = vld_q[6];
  assign side_o  = side_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign neg_o   = neg_q;

endmodule

// File: src/nbji_div.sv
// ----------------------------------------------------------------------------
// nbji_div
// pipelined restoring divider, one quotient bit per stage in every lane,
// round to nearest with ties away from zero, sign and saturation
// ----------------------------------------------------------------------------
module nbji_div #(
  parameter int DATA_WIDTH = nbji_pkg::DATA_WIDTH_DEF,
  parameter int EXT_WIDTH  = 4 * nbji_pkg::DATA_WIDTH_DEF + 1
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             en_i,
  input  logic                                             valid_i,
  input  nbji_pkg::side_t                                  side_i,
  input  logic [nbji_pkg::LANES-1:0][EXT_WIDTH-1:0]        num_i,
  input  logic [nbji_pkg::LANES-1:0][EXT_WIDTH-1:0]        den_i,
  input  logic [nbji_pkg::LANES-1:0]                       neg_i,
  output logic                                             valid_o,
  output nbji_pkg::side_t                                  side_o,
  output logic [nbji_pkg::LANES-1:0][DATA_WIDTH-1:0]       quo_o,
  output logic [nbji_pkg::LANES-1:0]                       sat_o
);

  localparam int W  = DATA_WIDTH;
  localparam int XW = EXT_WIDTH;
  localparam int NL = nbji_pkg::LANES;

  localparam logic [W:0]   MAXP = {2'b00, {(W-1){1'b1}}};
  localparam logic [W:0]   MAXN = {2'b01, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  logic [W:0]                         vld_q;
  nbji_pkg::side_t [W:0]              side_q;
  logic [W:0][NL-1:0][XW-1:0]         rem_q;
  logic [W:0][NL-1:0][XW-1:0]         den_q;
  logic [W:0][NL-1:0][W-1:0]          quo_q;
  logic [W:0][NL-1:0]                 neg_q;
  logic [W:0][NL-1:0]                 ovf_q;
  logic [W-1:0][NL-1:0][XW:0]         diff;

  logic                               vld_out_q;
  nbji_pkg::side_t                    side_out_q;
  logic [NL-1:0][W-1:0]               quo_d, quo_out_q;
  logic [NL-1:0]                      sat_d, sat_out_q;
  logic [NL-1:0]                      rnd;
  logic [NL-1:0][W:0]                 qf;

  always_comb begin
    for (int k = 0; k < W; k++) begin
      for (int l = 0; l < NL; l++) begin
        diff[k][l] = {1'b0, rem_q[k][l]} - {1'b0, XW'(den_q[k][l] << (W - 1 - k))};
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      rnd[l] = {rem_q[W][l], 1'b0} >= {1'b0, den_q[W][l]};
      qf[l]  = {1'b0, quo_q[W][l]} + (W+1)'(rnd[l]);
      if (ovf_q[W][l] || (!neg_q[W][l] && qf[l] > MAXP) || (neg_q[W][l] && qf[l] > MAXN)) begin
        sat_d[l] = 1'b1;
        quo_d[l] = neg_q[W][l] ? MINV : MAXV;
      end else begin
        sat_d[l] = 1'b0;
        quo_d[l] = neg_q[W][l] ? W'(-qf[l]) : W'(qf[l]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_out_q <= 1'b0;
    end else if (en_i) begin
      vld_q     <= {vld_q[W-1:0], valid_i};
      vld_out_q <= vld_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int l = 0; l < NL; l++) begin
        // quotient of more than W bits saturates
        ovf_q[0][l] <= num_i[l] >= XW'(den_i[l] << W);
        rem_q[0][l] <= num_i[l];
        den_q[0][l] <= den_i[l];
        quo_q[0][l] <= '0;
        neg_q[0][l] <= neg_i[l];
      end
      for (int k = 0; k < W; k++) begin
        side_q[k+1] <= side_q[k];
        for (int l = 0; l < NL; l++) begin
          rem_q[k+1][l] <= diff[k][l][XW] ? rem_q[k][l] : diff[k][l][XW-1:0];
          quo_q[k+1][l] <= quo_q[k][l] | (W'(!diff[k][l][XW]) << (W - 1 - k));
          den_q[k+1][l] <= den_q[k][l];
          neg_q[k+1][l] <= neg_q[k][l];
          ovf_q[k+1][l] <= ovf_q[k][l];
        end
      end
      side_out_q <= side_q[W];
      quo_out_q  <= quo_d;
      sat_out_q  <= sat_d;
    end
  end

  assign valid_o = vld_out_q;
  assign side_o  = side_out_q;
  assign quo_o   = quo_out_q;
  assign sat_o   = sat_out_q;

endmodule

// File: src/nbji_rows.sv
// ----------------------------------------------------------------------------
// nbji_rows
// holds one finished node block and sends its four rows, applying the
// identity overrides for singular parts and constrained rows
// ----------------------------------------------------------------------------
module nbji_rows #(
  parameter int DATA_WIDTH = nbji_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = nbji_pkg::FRAC_BITS_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             valid_i,
  output logic                                             ready_o,
  input  nbji_pkg::side_t                                  side_i,
  input  logic [nbji_pkg::LANES-1:0][DATA_WIDTH-1:0]       quo_i,
  input  logic [nbji_pkg::LANES-1:0]                       sat_i,
  output logic                                             m_valid_o,
  input  logic                                             m_ready_i,
  output logic [nbji_pkg::N_ROWS-1:0][DATA_WIDTH-1:0]      m_cols_o,
  output nbji_pkg::rflag_t                                 m_flags_o
);

  localparam int W  = DATA_WIDTH;
  localparam int NR = nbji_pkg::N_ROWS;
  localparam int VD = nbji_pkg::VEL_DIM;

  localparam bit           UNIT_SAT = (FRAC_BITS >= W - 1);
  localparam logic [W-1:0] UNIT_VAL = UNIT_SAT ? {1'b0, {(W-1){1'b1}}} : (W'(1) << FRAC_BITS);

  logic                                    held_q;
  logic [nbji_pkg::ROW_W-1:0]              row_q;
  nbji_pkg::side_t                         side_q;
  logic [nbji_pkg::LANES-1:0][W-1:0]       quo_q;
  logic [nbji_pkg::LANES-1:0]              sat_q;
  logic [NR-1:0][NR-1:0][W-1:0]            rv;
  logic [NR-1:0]                           rs;
  logic                                    load;

  assign ready_o = !held_q || (row_q == nbji_pkg::LAST_ROW && m_ready_i);
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
      row_q  <= nbji_pkg::FIRST_ROW;
    end else if (held_q && m_ready_i) begin
      if (row_q == nbji_pkg::LAST_ROW) begin
        held_q <= valid_i;
        row_q  <= nbji_pkg::FIRST_ROW;
      end else begin
        row_q <= row_q + 2'd1;
      end
    end else if (!held_q) begin
      held_q <= valid_i;
      row_q  <= nbji_pkg::FIRST_ROW;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      side_q <= side_i;
      quo_q  <= quo_i;
      sat_q  <= sat_i;
    end
  end

  always_comb begin
    rv = '0;
    rs = '0;
    for (int r = 0; r < NR; r++) begin
      for (int c = 0; c < NR; c++) begin
        if (side_q.mask[r]) begin
          if (r == c) begin
            rv[r][c] = UNIT_VAL;
            rs[r]    = rs[r] | UNIT_SAT;
          end
        end else if (r < VD && c < VD) begin
          if (side_q.vsing) begin
            if (r == c) begin
              rv[r][c] = UNIT_VAL;
              rs[r]    = rs[r] | UNIT_SAT;
            end
          end else begin
            rv[r][c] = quo_q[r*VD+c];
            rs[r]    = rs[r] | sat_q[r*VD+c];
          end
        end else if (r == VD && c == VD) begin
          if (side_q.psing) begin
            rv[r][c] = UNIT_VAL;
            rs[r]    = rs[r] | UNIT_SAT;
          end else begin
            rv[r][c] = quo_q[nbji_pkg::PRES_LANE];
            rs[r]    = rs[r] | sat_q[nbji_pkg::PRES_LANE];
          end
        end
      end
    end
  end

  assign m_valid_o       = held_q;
  assign m_cols_o        = rv[row_q];
  assign m_flags_o.sat   = rs[row_q];
  assign m_flags_o.psing = side_q.psing;
  assign m_flags_o.vsing = side_q.vsing;
  assign m_flags_o.row   = row_q;

  a_hold_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q && !m_ready_i |=> held_q && $stable(row_q))
    else $error("row changed while stalled");

  a_next_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q && m_ready_i && row_q != nbji_pkg::LAST_ROW |=>
      held_q && row_q == 2'($past(row_q) + 2'd1))
    else $error("row sequence broken");

  a_load_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> held_q && row_q == nbji_pkg::FIRST_ROW)
    else $error("new block did not start at row zero");

  a_mask_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q && side_q.mask[row_q] |-> m_flags_o.sat == UNIT_SAT)
    else $error("constrained row carries a computed clip flag");

endmodule

// File: src/node_block_jacobi_inverse.sv
// ----------------------------------------------------------------------------
// node_block_jacobi_inverse
// inverts one node's 4x4 diagonal block per item: 3x3 velocity part by
// cofactors, pressure entry by reciprocal, constrained rows set to identity
// ----------------------------------------------------------------------------
// path: an accepted item passes the determinant and divider pipelines and
//   the row buffer, then one row per cycle for four rows while the output
//   channel is ready; the node rate is set by the four rows on the output
//   channel; the divider pipeline takes a new item in any cycle it advances
// reset: asynchronous active low, clears all valid bits and the row counter
module node_block_jacobi_inverse #(
  parameter int DATA_WIDTH = nbji_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = nbji_pkg::FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // v00, v01, v02, v10, v11, v12, v20, v21, v22, pressure_diag
  input  logic [((nbji_pkg::LANES*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // constrained_rows
  input  logic [nbji_pkg::MASK_W-1:0] s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // col0, col1, col2, col3
  output logic [((nbji_pkg::N_ROWS*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata_o,
  // row_index, velocity_singular, pressure_singular, saturated
  output logic [4:0] m_axis_tuser_o,
  // last_row
  output logic m_axis_tlast_o
);

  localparam int W     = DATA_WIDTH;
  localparam int NUM_W = 2 * W + 2 * FRAC_BITS;
  localparam int XW    = ((NUM_W > 4 * W) ? NUM_W : 4 * W) + 1;
  localparam int OUT_W = ((nbji_pkg::N_ROWS*DATA_WIDTH+7)/8)*8;

  logic                                        adv;
  logic                                        det_vld;
  nbji_pkg::side_t                             det_side;
  logic [nbji_pkg::LANES-1:0][XW-1:0]          det_num;
  logic [nbji_pkg::LANES-1:0][XW-1:0]          det_den;
  logic [nbji_pkg::LANES-1:0]                  det_neg;
  logic                                        div_vld;
  nbji_pkg::side_t                             div_side;
  logic [nbji_pkg::LANES-1:0][W-1:0]           div_quo;
  logic [nbji_pkg::LANES-1:0]                  div_sat;
  logic                                        rows_ready;
  logic [nbji_pkg::N_ROWS-1:0][W-1:0]          cols;
  nbji_pkg::rflag_t                            flags;
  logic [nbji_pkg::LANES-1:0][W-1:0]           ent;

  assign adv             = !div_vld || rows_ready;
  assign s_axis_tready_o = adv;
  assign ent             = s_axis_tdata_i[nbji_pkg::LANES*W-1:0];

  nbji_det #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .EXT_WIDTH  (XW)
  ) u_det (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid_i),
    .ent_i   (ent),
    .mask_i  (s_axis_tuser_i),
    .valid_o (det_vld),
    .side_o  (det_side),
    .num_o   (det_num),
    .den_o   (det_den),
    .neg_o   (det_neg)
  );

  nbji_div #(
    .DATA_WIDTH (DATA_WIDTH),
    .EXT_WIDTH  (XW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (det_vld),
    .side_i  (det_side),
    .num_i   (det_num),
    .den_i   (det_den),
    .neg_i   (det_neg),
    .valid_o (div_vld),
    .side_o  (div_side),
    .quo_o   (div_quo),
    .sat_o   (div_sat)
  );

  nbji_rows #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_rows (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (div_vld),
    .ready_o   (rows_ready),
    .side_i    (div_side),
    .quo_i     (div_quo),
    .sat_i     (div_sat),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_cols_o  (cols),
    .m_flags_o (flags)
  );

  assign m_axis_tdata_o = OUT_W'(cols);
  assign m_axis_tuser_o = flags;
  assign m_axis_tlast_o = (flags.row == nbji_pkg::LAST_ROW);

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// checks node_block_jacobi_inverse: node blocks are streamed in with random
// gaps, each is predicted with exact wide integer math (cofactor inverse,
// pressure reciprocal, masked identity rows, rounding and clipping), and the
// four rows coming out are compared field by field against the prediction
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef logic signed [DW-1:0] word_t;

  typedef struct {
    word_t                       ent [9];
    word_t                       pres;
    logic [nbji_pkg::MASK_W-1:0] mask;
  } node_t;

  typedef struct {
    logic [nbji_pkg::ROW_W-1:0] row;
    word_t                      col [4];
    logic                       vsing;
    logic                       psing;
    logic                       sat;
    logic                       last;
  } inv_row_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid_i = 0;
  logic s_axis_tready_o;
  logic [nbji_pkg::LANES*DW-1:0] s_axis_tdata_i = '0;
  logic [nbji_pkg::MASK_W-1:0] s_axis_tuser_i = '0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 0;
  logic [nbji_pkg::N_ROWS*DW-1:0] m_axis_tdata_o;
  logic [4:0] m_axis_tuser_o;
  logic m_axis_tlast_o;

  inv_row_t expected_rows [$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_off = 0;
  bit sink_busy = 0;

  node_block_jacobi_inverse u_top (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic word_t clip_to_word(logic signed [255:0] v, ref logic sat);
    logic signed [255:0] hi, lo;
    hi = (256'sd1 <<< (DW - 1)) - 1;
    lo = -(256'sd1 <<< (DW - 1));
    if (v > hi) begin
      sat = 1;
      return hi[DW-1:0];
    end
    if (v < lo) begin
      sat = 1;
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // rounded to nearest, ties away from zero
  function automatic logic signed [255:0] div_round(logic signed [255:0] n,
                                                     logic signed [255:0] d);
    logic signed [255:0] an, ad, q, r;
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    q = an / ad;
    r = an % ad;
    if (2 * r >= ad) q = q + 1;
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  task automatic predict_inverse(node_t nd);
    logic signed [255:0] e [9];
    logic signed [255:0] adj [9];
    logic signed [255:0] ent [4][4];
    logic signed [255:0] det, unit;
    logic vsing, psing, sat;
    inv_row_t r;
    for (int i = 0; i < 9; i++) e[i] = nd.ent[i];
    for (int j = 0; j < nbji_pkg::N_ENT; j++)
      adj[j] = e[nbji_pkg::ADJ_P[j]] * e[nbji_pkg::ADJ_Q[j]]
             - e[nbji_pkg::ADJ_S[j]] * e[nbji_pkg::ADJ_T[j]];
    det = e[0] * adj[0] + e[3] * adj[1] + e[6] * adj[2];
    unit = 256'sd1 <<< FB;
    vsing = det == 0;
    psing = nd.pres == 0;
    for (int a = 0; a < 4; a++)
      for (int b = 0; b < 4; b++) ent[a][b] = 0;
    for (int a = 0; a < 3; a++)
      for (int b = 0; b < 3; b++)
        ent[a][b] = vsing ? ((a == b) ? unit : 0) : div_round(adj[a*3+b] <<< (2*FB), det);
    ent[3][3] = psing ? unit : div_round(256'sd1 <<< (2*FB), 256'(nd.pres));
    for (int a = 0; a < 4; a++)
      if (nd.mask[a]) begin
        for (int b = 0; b < 4; b++) ent[a][b] = 0;
        ent[a][a] = unit;
      end
    for (int a = 0; a < 4; a++) begin
      sat = 0;
      r.row = nbji_pkg::ROW_W'(a);
      for (int b = 0; b < 4; b++) r.col[b] = clip_to_word(ent[a][b], sat);
      r.vsing = vsing;
      r.psing = psing;
      r.sat = sat;
      r.last = a == 3;
      expected_rows = {expected_rows, r};
    end
  endtask

  task automatic send_node(node_t nd);
    int gap;
    gap = $urandom_range(0, 3);
    repeat (gap) @(negedge clk_i);
    for (int i = 0; i < 9; i++) s_axis_tdata_i[i*DW +: DW] = nd.ent[i];
    s_axis_tdata_i[nbji_pkg::PRES_LANE*DW +: DW] = nd.pres;
    s_axis_tuser_i = nd.mask;
    s_axis_tvalid_i = 1;
    predict_inverse(nd);
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
    s_axis_tvalid_i = 0;
  endtask

  function automatic word_t rand_word(int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom_range(0, 3) - 1;
    endcase
  endfunction

  function automatic node_t rand_node();
    node_t nd;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++)
      nd.ent[i] = rand_word(kind < 3 ? 1 : kind < 5 ? 0 : kind < 7 ? $urandom_range(0, 3) : 3);
    if (kind == 9) for (int i = 0; i < 3; i++) nd.ent[6+i] = nd.ent[i];
    nd.pres = rand_word($urandom_range(0, 3));
    nd.mask = ($urandom_range(0, 3) == 0) ? nbji_pkg::MASK_W'($urandom) : 4'h0;
    return nd;
  endfunction

  function automatic node_t diag_node(word_t d, word_t p, logic [3:0] m);
    node_t nd;
    for (int i = 0; i < 9; i++) nd.ent[i] = (i % 4 == 0) ? d : 0;
    nd.pres = p;
    nd.mask = m;
    return nd;
  endfunction

  task automatic test_directed();
    node_t nd;
    send_node(diag_node(32'sh00010000, 32'sh00010000, 4'h0));
    send_node(diag_node(32'sh00020000, 32'shfffe0000, 4'h0));
    send_node(diag_node(32'sh0, 32'sh0, 4'h0));
    send_node(diag_node(32'sh1, 32'sh1, 4'h0));
    send_node(diag_node(32'sh80000000, 32'sh80000000, 4'h0));
    send_node(diag_node(32'sh7fffffff, 32'sh7fffffff, 4'hf));
    send_node(diag_node(32'sh00010000, 32'shffffffff, 4'h5));
    send_node(diag_node(32'sh3, 32'sh3, 4'ha));
    for (int i = 0; i < 9; i++) nd.ent[i] = 32'sh7fffffff;
    nd.pres = 32'sh00008000;
    nd.mask = 4'h0;
    send_node(nd);
    for (int i = 0; i < 9; i++) nd.ent[i] = 32'sh80000000 + (i % 2);
    nd.pres = 32'sh12345678;
    nd.mask = 4'h9;
    send_node(nd);
    for (int i = 0; i < 9; i++) nd.ent[i] = (i + 1) * 32'sh00010000;
    nd.ent[8] = 32'sh000a0000;
    nd.pres = 32'shedcba987;
    nd.mask = 4'h6;
    send_node(nd);
  endtask

  task automatic test_random();
    repeat (80) send_node(rand_node());
  endtask

  task automatic test_backpressure();
    hold_off = 1;
    wait (sink_busy);
    repeat (30) send_node(rand_node());
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    test_directed();
    test_backpressure();
    test_random();
    while (expected_rows.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (errors == 0) $display("PASS node_block_jacobi_inverse");
    else $display("FAIL node_block_jacobi_inverse");
    $finish;
  end

  // ready driver, with a long hold-off on request
  initial begin
    int wait_n;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready_i <= 0;
        sink_busy = 1;
        repeat (300) @(negedge clk_i);
        hold_off = 0;
        sink_busy = 0;
      end else begin
        wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
        if (wait_n != 0) begin
          m_axis_tready_i <= 0;
          repeat (wait_n - 1) @(negedge clk_i);
        end else begin
          m_axis_tready_i <= 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    inv_row_t x;
    nbji_pkg::rflag_t fl;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      fl = m_axis_tuser_o;
      if (expected_rows.size() == 0) begin
        $display("%0t unexpected row: actual row=%0d", $time, fl.row);
        errors++;
      end else begin
        x = expected_rows.pop_front();
        if (fl.row !== x.row || fl.vsing !== x.vsing || fl.psing !== x.psing ||
            fl.sat !== x.sat || m_axis_tlast_o !== x.last) begin
          $display("%0t flags mismatch: expected row=%0d vs=%b ps=%b sat=%b last=%b",
                   $time, x.row, x.vsing, x.psing, x.sat, x.last);
          $display("%0t   actual row=%0d vs=%b ps=%b sat=%b last=%b",
                   $time, fl.row, fl.vsing, fl.psing, fl.sat, m_axis_tlast_o);
          errors++;
        end
        for (int b = 0; b < 4; b++)
          if (m_axis_tdata_o[b*DW +: DW] !== x.col[b]) begin
            $display("%0t row %0d col%0d mismatch: expected %h actual %h",
                     $time, x.row, b, x.col[b], m_axis_tdata_o[b*DW +: DW]);
            errors++;
          end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL node_block_jacobi_inverse");
      $finish;
    end
  end

endmodule

// File: sim.f
src/nbji_pkg.sv
src/nbji_det.sv
src/nbji_div.sv
src/nbji_rows.sv
src/node_block_jacobi_inverse.sv
sim/tb_top.sv
